// ===== design/mmt_pkg.sv =====
// Shared types and constants for the multiset mex tracker.
// No dependencies; compile first.
package mmt_pkg;

  // Fixed field widths of the item and result transactions
  localparam int ITEM_VALUE_W = 16;
  localparam int MEX_VALUE_W  = 9;

  // Operation code carried by each item
  typedef enum logic {
    FUNC_ADD    = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

endpackage

// ===== design/mmt_item_if.sv =====
// Item channel: valid/ready handshake with operation and value.
// Depends on mmt_pkg.
interface mmt_item_if
  import mmt_pkg::*;
();
  logic                    valid;
  logic                    ready;
  func_e                   func;
  logic [ITEM_VALUE_W-1:0] item_value;

  modport source (output valid, func, item_value, input ready);
  modport sink   (input valid, func, item_value, output ready);
endinterface

// ===== design/mmt_result_if.sv =====
// Result channel: valid/ready handshake with mex value and ignored flag.
// Depends on mmt_pkg.
interface mmt_result_if
  import mmt_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [MEX_VALUE_W-1:0] mex_value;
  logic                   ignored;

  modport source (output valid, mex_value, ignored, input ready);
  modport sink   (input valid, mex_value, ignored, output ready);
endinterface

// ===== design/multiset_mex_tracker.sv =====
// Multiset mex tracker: one occurrence count and one presence bit per tracked value.
// Depends on mmt_pkg, mmt_item_if and mmt_result_if.
//
// The block accepts one item per clock cycle unless the result side stalls, and
// returns one result per item through the input/read register, the update stage and
// the result register. The rate is set by the read-modify-write of the count memory,
// which uses a bypass of the last write. The presence bits are flip-flops cleared
// by reset and mark which count entries hold data, so the count memory needs no
// clearing pass: the block is ready as soon as reset is released. A stall on the
// result side holds the whole pipeline; mex_value is the smallest value in
// 0..MAX_VALUE+1 with a zero count, truncated to the 9-bit field.
module multiset_mex_tracker
  import mmt_pkg::*;
#(
  parameter int MAX_VALUE  = 255,
  parameter int COUNT_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mmt_item_if.sink     item_i,
  mmt_result_if.source result_o
);

  localparam int TRACKED = MAX_VALUE + 1;
  localparam int IDX_W   = $clog2(TRACKED);
  localparam int MEX_W   = $clog2(TRACKED + 1);
  localparam int PAD_N   = 2 ** MEX_W;
  localparam int WIDE_W  = MEX_W + MEX_VALUE_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Count store; an entry is meaningful only while its presence bit is set
  logic [COUNT_BITS-1:0] cnt_mem [TRACKED];
  logic [TRACKED-1:0]    present_q;

  // Pipeline control
  logic en;
  logic in_acc;
  logic in_range;
  logic s1_vld_q, s2_vld_q, out_vld_q;

  // Stage 1 registers
  func_e                 s1_func_q;
  logic [IDX_W-1:0]      s1_idx_q;
  logic                  s1_inr_q;
  logic [COUNT_BITS-1:0] rd_q;

  // Last write, for bypass of a read that raced it
  logic                  lw_vld_q;
  logic [IDX_W-1:0]      lw_idx_q;
  logic [COUNT_BITS-1:0] lw_data_q;

  // Stage 1 update logic
  logic [COUNT_BITS-1:0] cnt_cur, cnt_d;
  logic                  skip_d;
  logic                  wr_en;

  // Stage 2 and result registers
  logic                   s2_ign_q;
  logic [MEX_VALUE_W-1:0] mex_q;
  logic                   ign_q;

  // Mex search
  logic [PAD_N-1:0]       absent;
  logic                   lv_f [MEX_W+1][PAD_N];
  logic [MEX_W-1:0]       lv_i [MEX_W+1][PAD_N];
  logic [MEX_W-1:0]       mex_raw;
  logic [WIDE_W-1:0]      mex_wide;

  // Whole pipeline advances unless a result is stuck at the output
  assign en           = !out_vld_q || result_o.ready;
  assign item_i.ready = en;
  assign in_acc       = item_i.valid && en;
  assign in_range     = {16'd0, item_i.item_value} <= 32'(MAX_VALUE);

  // Current count with bypass of the last write; absent entries read as zero
  always_comb begin
    if (!present_q[s1_idx_q]) begin
      cnt_cur = '0;
    end else if (lw_vld_q && (lw_idx_q == s1_idx_q)) begin
      cnt_cur = lw_data_q;
    end else begin
      cnt_cur = rd_q;
    end
  end

  // Apply add or remove, flag skipped transactions
  always_comb begin
    cnt_d  = cnt_cur;
    skip_d = 1'b0;
    if (!s1_inr_q) begin
      skip_d = 1'b1;
    end else begin
      case (s1_func_q)
        FUNC_ADD: begin
          if (cnt_cur == CNT_MAX) begin
            skip_d = 1'b1;
          end else begin
            cnt_d = cnt_cur + 1'b1;
          end
        end
        FUNC_REMOVE: begin
          if (cnt_cur == '0) begin
            skip_d = 1'b1;
          end else begin
            cnt_d = cnt_cur - 1'b1;
          end
        end
        default: skip_d = 1'b1;
      endcase
    end
  end

  assign wr_en = en && s1_vld_q && !skip_d;

  // Count memory: registered read at item acceptance, write from stage 1
  always_ff @(posedge clk_i) begin
    if (in_acc && in_range) begin
      rd_q <= cnt_mem[item_i.item_value[IDX_W-1:0]];
    end
    if (wr_en) begin
      cnt_mem[s1_idx_q] <= cnt_d;
    end
  end

  // Find the lowest absent value; values past the tracked range count as absent
  always_comb begin
    absent                = '1;
    absent[TRACKED-1:0]   = ~present_q;
    for (int l = 0; l <= MEX_W; l++) begin
      for (int j = 0; j < PAD_N; j++) begin
        lv_f[l][j] = 1'b0;
        lv_i[l][j] = '0;
      end
    end
    for (int j = 0; j < PAD_N; j++) begin
      lv_f[0][j] = absent[j];
    end
    for (int l = 0; l < MEX_W; l++) begin
      for (int j = 0; j < PAD_N / 2; j++) begin
        if (j < (PAD_N >> (l + 1))) begin
          lv_f[l+1][j] = lv_f[l][2*j] | lv_f[l][2*j+1];
          if (lv_f[l][2*j]) begin
            lv_i[l+1][j] = lv_i[l][2*j];
          end else begin
            lv_i[l+1][j] = lv_i[l][2*j+1] | MEX_W'(1 << l);
          end
        end
      end
    end
    mex_raw  = lv_i[MEX_W][0];
    mex_wide = WIDE_W'(mex_raw);
  end

  // Hold control state, presence bits and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      lw_vld_q  <= 1'b0;
      present_q <= '0;
    end else if (en) begin
      s1_vld_q  <= item_i.valid;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
      if (wr_en) begin
        lw_vld_q            <= 1'b1;
        present_q[s1_idx_q] <= (cnt_d != '0);
      end
    end
  end

  // Payload registers advance with the pipeline
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_func_q <= item_i.func;
      s1_idx_q  <= item_i.item_value[IDX_W-1:0];
      s1_inr_q  <= in_range;
      s2_ign_q  <= skip_d;
      mex_q     <= mex_wide[MEX_VALUE_W-1:0];
      ign_q     <= s2_ign_q;
      if (wr_en) begin
        lw_idx_q  <= s1_idx_q;
        lw_data_q <= cnt_d;
      end
    end
  end

  assign result_o.valid     = out_vld_q;
  assign result_o.mex_value = mex_q;
  assign result_o.ignored   = ign_q;

endmodule
